[design/byte_ent_pkg.sv]
// Shared constants, types and state codes for the byte entropy estimator.
package byte_ent_pkg;

  localparam int COUNT_BITS = 24;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_BINS   = 256;
  localparam int BIN_BITS   = 8;
  localparam int LOG_FRAC   = 32;

  localparam int ENT_BITS    = FRAC_BITS + 4;
  localparam int EXP_BITS    = $clog2(COUNT_BITS);
  localparam int LOG_BITS    = EXP_BITS + LOG_FRAC;
  localparam int ACC_BITS    = COUNT_BITS + LOG_BITS;
  localparam int MUL_BITS    = (COUNT_BITS > 32) ? COUNT_BITS : 32;
  localparam int LG_CNT_BITS = $clog2(LOG_FRAC);
  localparam int ROUND_SHIFT = LOG_FRAC - FRAC_BITS;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD,
    ST_LG_INIT,
    ST_LG_SQ,
    ST_LG_BIT,
    ST_BIN_RD,
    ST_BIN_CHK,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_ACC,
    ST_DIV_GO,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

  // Control between the sequencer and the divider.
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic done;
  } div_rsp_t;

endpackage

[design/byte_ent_if.sv]
// Handshake interfaces for the byte input channel and the result channel.
interface byte_ent_in_if import byte_ent_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface byte_ent_out_if import byte_ent_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ENT_BITS-1:0]   entropy_bits;
  logic [COUNT_BITS-1:0] message_length;
  logic                  count_overflow;

  modport source (output valid, output entropy_bits, output message_length,
                  output count_overflow, input ready);
  modport sink (input valid, input entropy_bits, input message_length,
                input count_overflow, output ready);
endinterface

[design/byte_entropy_estimator.sv]
// Byte histogram with Shannon entropy computed on the last byte of each message.
// Each byte is a histogram read, then an increment and write back.
// On the last byte: log2 of the total, then per bin a read and a check, and for a
// non-empty bin its log2 (32 squarings on the shared multiplier) and two partial
// products, then the divider and a rounding step before the result.
// Synchronous reset clears the histogram valid bits, count, flag and sequencer.
module byte_entropy_estimator import byte_ent_pkg::*; (
  input logic            clk,
  input logic            rst,
  byte_ent_in_if.sink    in_ch,
  byte_ent_out_if.source out_ch
);

  state_t state, state_next;

  // Histogram storage and per-bin valid bits.
  logic [COUNT_BITS-1:0] bin_mem [NUM_BINS];
  logic [NUM_BINS-1:0]   bin_valid;
  logic [COUNT_BITS-1:0] rd_q;
  logic [BIN_BITS-1:0]   rd_addr;

  logic [BIN_BITS-1:0]   cur_byte;
  logic                  cur_last;
  logic [COUNT_BITS-1:0] total_count;
  logic                  overflow_seen;
  logic [BIN_BITS-1:0]   bin_idx;
  logic [COUNT_BITS-1:0] cur_count;
  logic [COUNT_BITS-1:0] bin_old;
  logic [COUNT_BITS-1:0] total_next;

  // Log2 unit state.
  logic [COUNT_BITS-1:0]  lg_x;
  logic                   lg_for_total;
  logic [EXP_BITS-1:0]    lg_e;
  logic [EXP_BITS-1:0]    lg_e_c;
  logic [31:0]            lg_y;
  logic [LOG_FRAC-1:0]    lg_frac;
  logic [LG_CNT_BITS-1:0] lg_cnt;
  logic [COUNT_BITS+30:0] lg_norm;
  logic [32:0]            sq_t;
  logic [LOG_BITS-1:0]    lg_val;
  logic [LOG_BITS-1:0]    ln_total;
  logic [LOG_BITS-1:0]    d_val;

  // Shared multiplier.
  logic [MUL_BITS-1:0]   mul_a, mul_b;
  logic [2*MUL_BITS-1:0] mul_p;

  logic [ACC_BITS-1:0] acc;
  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic [ACC_BITS-1:0] quot;
  logic [ACC_BITS:0]   rounded;

  logic [ENT_BITS-1:0]   ent_q;
  logic [COUNT_BITS-1:0] len_q;
  logic                  ovf_q;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_ch.valid) state_next = ST_UPD;
      ST_UPD:     state_next = cur_last ? ST_LG_INIT : ST_IDLE;
      ST_LG_INIT: state_next = ST_LG_SQ;
      ST_LG_SQ:   state_next = ST_LG_BIT;
      ST_LG_BIT: begin
        if (lg_cnt != LG_CNT_BITS'(LOG_FRAC - 1)) state_next = ST_LG_SQ;
        else if (lg_for_total) state_next = ST_BIN_RD;
        else state_next = ST_MUL_LO;
      end
      ST_BIN_RD:  state_next = ST_BIN_CHK;
      ST_BIN_CHK: begin
        if (bin_valid[bin_idx] && rd_q != '0) state_next = ST_LG_INIT;
        else if (bin_idx == BIN_BITS'(NUM_BINS - 1)) state_next = ST_DIV_GO;
        else state_next = ST_BIN_RD;
      end
      ST_MUL_LO:  state_next = ST_MUL_HI;
      ST_MUL_HI:  state_next = ST_MUL_ACC;
      ST_MUL_ACC: begin
        state_next = (bin_idx == BIN_BITS'(NUM_BINS - 1)) ? ST_DIV_GO : ST_BIN_RD;
      end
      ST_DIV_GO:  state_next = ST_DIV;
      ST_DIV:     if (div_rsp.done) state_next = ST_FIN;
      ST_FIN:     state_next = ST_OUT;
      ST_OUT:     if (out_ch.ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ch.ready   = 1'b0;
    out_ch.valid  = 1'b0;
    div_req.start = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    rd_addr       = bin_idx;
    unique case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        rd_addr     = in_ch.data_byte;
      end
      ST_LG_SQ: begin
        mul_a = MUL_BITS'(lg_y);
        mul_b = MUL_BITS'(lg_y);
      end
      ST_MUL_LO: begin
        mul_a = MUL_BITS'(cur_count);
        mul_b = MUL_BITS'(d_val[31:0]);
      end
      ST_MUL_HI: begin
        mul_a = MUL_BITS'(cur_count);
        mul_b = MUL_BITS'(d_val[LOG_BITS-1:32]);
      end
      ST_DIV_GO: div_req.start = 1'b1;
      ST_OUT:    out_ch.valid  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Histogram memory port.
  always_ff @(posedge clk) begin
    rd_q <= bin_mem[rd_addr];
    if (state == ST_UPD) begin
      bin_mem[cur_byte] <= (bin_old == '1) ? bin_old : bin_old + 1'b1;
    end
  end

  always_comb begin
    bin_old    = bin_valid[cur_byte] ? rd_q : '0;
    total_next = (total_count == '1) ? total_count : total_count + 1'b1;
  end

  // Leading one and normalization of the log operand, the log result and the rounded quotient.
  always_comb begin
    lg_e_c = '0;
    for (int i = 0; i < COUNT_BITS; i++) begin
      if (lg_x[i]) lg_e_c = EXP_BITS'(i);
    end
    lg_norm = {lg_x, 31'b0} >> lg_e_c;
    sq_t    = mul_p[63:31];
    lg_val  = {lg_e, lg_frac[LOG_FRAC-2:0], sq_t[32]};
    rounded = ({1'b0, quot} + (ACC_BITS+1)'(1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid     <= '0;
      total_count   <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (state == ST_UPD) begin
        bin_valid[cur_byte] <= 1'b1;
        total_count         <= total_next;
        if (total_count == '1 || bin_old == '1) overflow_seen <= 1'b1;
      end
      if (state == ST_FIN) begin
        bin_valid     <= '0;
        total_count   <= '0;
        overflow_seen <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    case (state)
      ST_IDLE: begin
        cur_byte <= in_ch.data_byte;
        cur_last <= in_ch.last_byte;
      end
      ST_UPD: begin
        lg_x         <= total_next;
        lg_for_total <= 1'b1;
        acc          <= '0;
        bin_idx      <= '0;
      end
      ST_LG_INIT: begin
        lg_e    <= lg_e_c;
        lg_y    <= lg_norm[31:0];
        lg_frac <= '0;
        lg_cnt  <= '0;
      end
      ST_LG_BIT: begin
        lg_y    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
        lg_frac <= {lg_frac[LOG_FRAC-2:0], sq_t[32]};
        lg_cnt  <= lg_cnt + 1'b1;
        if (lg_cnt == LG_CNT_BITS'(LOG_FRAC - 1)) begin
          if (lg_for_total) ln_total <= lg_val;
          else d_val <= (lg_val < ln_total) ? ln_total - lg_val : '0;
        end
      end
      ST_BIN_CHK: begin
        cur_count    <= rd_q;
        lg_x         <= rd_q;
        lg_for_total <= 1'b0;
        if (!(bin_valid[bin_idx] && rd_q != '0)) bin_idx <= bin_idx + 1'b1;
      end
      ST_MUL_HI:  acc <= acc + ACC_BITS'(mul_p);
      ST_MUL_ACC: begin
        acc     <= acc + ACC_BITS'({mul_p, 32'b0});
        bin_idx <= bin_idx + 1'b1;
      end
      ST_FIN: begin
        ent_q <= (rounded > (ACC_BITS+1)'(8 << FRAC_BITS)) ?
                 ENT_BITS'(8 << FRAC_BITS) : rounded[ENT_BITS-1:0];
        len_q <= total_count;
        ovf_q <= overflow_seen;
      end
      default: ;
    endcase
  end

  byte_ent_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (acc),
    .divisor  (total_count),
    .rsp      (div_rsp),
    .quotient (quot)
  );

  assign out_ch.entropy_bits   = ent_q;
  assign out_ch.message_length = len_q;
  assign out_ch.count_overflow = ovf_q;

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid))
    else $error("input and output active together");
  a_accept_upd: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (state == ST_UPD))
    else $error("accepted byte not counted");
  a_total_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BIN_RD || state == ST_DIV_GO) |-> (total_count != '0))
    else $error("entropy pass with empty message");
  a_cleared: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready) |=> (bin_valid == '0 && total_count == '0))
    else $error("histogram not cleared after result");
`endif

endmodule

[design/byte_ent_div.sv]
// Restoring divider, one quotient bit per cycle.
module byte_ent_div import byte_ent_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  div_req_t              req,
  input  logic [ACC_BITS-1:0]   dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output div_rsp_t              rsp,
  output logic [ACC_BITS-1:0]   quotient
);

  localparam int CNT_BITS = $clog2(ACC_BITS + 1);

  logic [ACC_BITS-1:0]   num;
  logic [COUNT_BITS:0]   rem;
  logic [CNT_BITS-1:0]   cnt;
  logic                  busy;
  logic [COUNT_BITS+1:0] trial;
  logic [COUNT_BITS:0]   shifted;

  // One shift and trial subtract per cycle.
  always_comb begin
    shifted = {rem[COUNT_BITS-1:0], num[ACC_BITS-1]};
    trial   = {1'b0, shifted} - {2'b00, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
      cnt      <= '0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(ACC_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy     <= 1'b0;
          rsp.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num      <= dividend;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      num <= {num[ACC_BITS-2:0], 1'b0};
      if (!trial[COUNT_BITS+1]) begin
        rem      <= trial[COUNT_BITS:0];
        quotient <= {quotient[ACC_BITS-2:0], 1'b1};
      end else begin
        rem      <= shifted;
        quotient <= {quotient[ACC_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

[tb/testbench.sv]
// Self-checking testbench for the byte entropy estimator.
`timescale 1ns / 100ps

module testbench;
  import byte_ent_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int HOLD_CYCLES    = 3000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic [ENT_BITS-1:0]   entropy_bits;
    logic [COUNT_BITS-1:0] message_length;
    logic                  count_overflow;
  } entropy_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  byte_ent_in_if  in_ch ();
  byte_ent_out_if out_ch ();

  byte_entropy_estimator dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: the histogram of the message in progress.
  logic [COUNT_BITS-1:0] hist_bins [NUM_BINS];
  logic [COUNT_BITS-1:0] msg_total;
  logic                  msg_overflow;

  byte_item_t      pending_bytes [$];
  entropy_result_t expected_results [$];
  int  error_count   = 0;
  int  results_seen  = 0;
  int  bytes_sent    = 0;
  bit  send_paused   = 1'b0;
  bit  recv_hold     = 1'b0;
  bit  quiet_phase   = 1'b0;
  int  idle_run      = 0;
  event hold_start;

  // Fixed-point log2 of a count with LOG_FRAC fraction bits.
  function automatic logic [63:0] log2_q32(logic [63:0] x);
    logic [63:0]  mant;
    logic [127:0] sq;
    logic [31:0]  frac_part;
    int           lead;
    frac_part = '0;
    lead = 0;
    if (x == 0) return 64'd0;
    for (int i = 0; i < 64; i++) if (x[i]) lead = i;
    mant = (lead >= 31) ? (x >> (lead - 31)) : (x << (31 - lead));
    for (int i = 0; i < LOG_FRAC; i++) begin
      sq = mant * mant;
      mant = sq[94:31];
      frac_part = frac_part << 1;
      if (mant >= 64'h1_0000_0000) begin
        mant = mant >> 1;
        frac_part[0] = 1'b1;
      end
    end
    return (64'(lead) << LOG_FRAC) | 64'(frac_part);
  endfunction

  // Entropy of the current histogram, rounded to FRAC_BITS fraction bits.
  function automatic logic [63:0] histogram_entropy();
    logic [127:0] weighted_sum;
    logic [127:0] quot;
    logic [63:0]  log_total, log_bin;
    weighted_sum = '0;
    if (msg_total == 0) return 64'd0;
    log_total = log2_q32(64'(msg_total));
    for (int b = 0; b < NUM_BINS; b++) begin
      if (hist_bins[b] != 0) begin
        log_bin = log2_q32(64'(hist_bins[b]));
        if (log_bin < log_total)
          weighted_sum += 128'(hist_bins[b]) * 128'(log_total - log_bin);
      end
    end
    quot = weighted_sum / 128'(msg_total);
    quot = (quot[63:0] + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
    if (quot > (128'd8 << FRAC_BITS)) quot = 128'd8 << FRAC_BITS;
    return quot[63:0];
  endfunction

  // Count one accepted byte and queue a result on the last one.
  task automatic count_byte(byte_item_t it);
    entropy_result_t r;
    logic [63:0] ent;
    if (msg_total == '1) msg_overflow = 1'b1;
    else msg_total++;
    if (hist_bins[it.data_byte] == '1) msg_overflow = 1'b1;
    else hist_bins[it.data_byte]++;
    if (it.last_byte) begin
      ent = histogram_entropy();
      r.entropy_bits   = ent[ENT_BITS-1:0];
      r.message_length = msg_total;
      r.count_overflow = msg_overflow;
      expected_results.push_back(r);
      foreach (hist_bins[b]) hist_bins[b] = '0;
      msg_total    = '0;
      msg_overflow = 1'b0;
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic bit idle_now();
    return !quiet_phase && ($urandom_range(99) < 14);
  endfunction

  // Driver: offers queued bytes, one per accepted handshake.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid     <= 1'b0;
      in_ch.data_byte <= '0;
      in_ch.last_byte <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        count_byte(byte_item_t'{in_ch.data_byte, in_ch.last_byte});
        bytes_sent++;
      end
      if ((!in_ch.valid || in_ch.ready)) begin
        if (pending_bytes.size() > 0 && !send_paused && !idle_now()) begin
          byte_item_t nxt;
          nxt = pending_bytes.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.data_byte <= nxt.data_byte;
          in_ch.last_byte <= nxt.last_byte;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver hold-off: keeps ready low after each hold_start until the hold count runs out.
  always begin
    @(hold_start);
    recv_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    recv_hold = 1'b0;
  end

  // Monitor: checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_ch.message_length, 0);
        end else begin
          entropy_result_t want;
          want = expected_results.pop_front();
          if (out_ch.entropy_bits !== want.entropy_bits)
            report_mismatch("entropy_bits", out_ch.entropy_bits, want.entropy_bits);
          if (out_ch.message_length !== want.message_length)
            report_mismatch("message_length", out_ch.message_length, want.message_length);
          if (out_ch.count_overflow !== want.count_overflow)
            report_mismatch("count_overflow", out_ch.count_overflow, want.count_overflow);
        end
      end
      out_ch.ready <= !recv_hold && !idle_now();
    end
  end

  // Watchdog: ends the run when nothing is accepted for too long.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic queue_message(int len, int mode);
    byte_item_t it;
    byte base;
    base = 8'($urandom);
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: it.data_byte = 8'($urandom);
        1: it.data_byte = base;
        2: it.data_byte = base + 8'($urandom_range(3));
        default: it.data_byte = 8'(i);
      endcase
      it.last_byte = (i == len - 1);
      pending_bytes.push_back(it);
    end
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    foreach (hist_bins[b]) hist_bins[b] = '0;
    msg_total    = '0;
    msg_overflow = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: single bytes at the extremes, a constant message, two values,
    // and a message of all 256 values for maximal entropy.
    pending_bytes.push_back('{8'h00, 1'b1});
    pending_bytes.push_back('{8'hFF, 1'b1});
    pending_bytes.push_back('{8'hA5, 1'b0});
    pending_bytes.push_back('{8'hA5, 1'b0});
    pending_bytes.push_back('{8'hA5, 1'b1});
    pending_bytes.push_back('{8'h5A, 1'b0});
    pending_bytes.push_back('{8'h81, 1'b1});
    pending_bytes.push_back('{8'h00, 1'b0});
    pending_bytes.push_back('{8'h00, 1'b0});
    pending_bytes.push_back('{8'h7F, 1'b1});
    queue_message(256, 3);
    wait_drained();

    // Receiver holds off while the sender keeps offering bytes.
    for (int m = 0; m < 6; m++) queue_message($urandom_range(1, 4), 0);
    -> hold_start;
    @(posedge clk);
    wait (!recv_hold);
    wait_drained();

    // Random messages; a stretch in the middle runs with no idling.
    while (bytes_sent < 1500) begin
      if (bytes_sent > 700 && bytes_sent < 900) quiet_phase = 1'b1;
      else quiet_phase = 1'b0;
      queue_message(($urandom_range(9) == 0) ? $urandom_range(20, 120)
                                             : $urandom_range(1, 12),
                    $urandom_range(3));
      if ($urandom_range(15) == 0) begin
        send_paused = 1'b1;
        wait (expected_results.size() == 0 && !in_ch.valid);
        send_paused = 1'b0;
      end
      while (pending_bytes.size() > 8) @(posedge clk);
    end
    quiet_phase = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d bytes in %0d messages, incl. constant, two-value,",
             bytes_sent, results_seen);
    $display("full-alphabet and back-pressure cases.");
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[files.f]
design/byte_ent_pkg.sv
design/byte_ent_if.sv
design/byte_ent_div.sv
design/byte_entropy_estimator.sv
tb/testbench.sv
